// ===== hdl/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, constants and the CORDIC arctangent table for the
// quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

   localparam int QUAT_FRAC_BITS = 14;
   localparam int CORDIC_STEPS   = 16;
   localparam int TABLE_LEN      = 24;

   localparam int QW      = 16;                       // quaternion component width
   localparam int PROD_W  = 2 * QW;                   // one component product
   // operand width of the atan2 inputs (sums, doubled, offset by one)
   localparam int OPW     = ((2 * QUAT_FRAC_BITS + 2 > PROD_W + 2) ?
                             2 * QUAT_FRAC_BITS + 2 : PROD_W + 2) + 1;
   localparam int CW      = OPW + 2;                  // CORDIC x/y width with growth
   localparam int ANG_FRAC = 16;
   localparam int ZW      = 32;                       // angle accumulator width
   localparam int SINE_W  = 31;                       // pitch sine, 30 fraction bits
   localparam int SQ_IN_W = 61;                       // 2^60 - s^2
   localparam int SQRT_STAGES = 31;
   localparam int ROOT_W  = 31;
   localparam int ANG_W   = 16;
   localparam int PITCH_W = 15;

   localparam logic signed [ZW-1:0] NINETY_Z = ZW'(64'sd9000 <<< ANG_FRAC);
   localparam logic signed [ANG_W-1:0] ANG_MAX = 16'sd18000;
   localparam logic signed [PITCH_W-1:0] PITCH_MAX = 15'sd9000;

   // atan(2^-i) in centidegrees with 16 fraction bits
   function automatic logic signed [ZW-1:0] atan_tab(input int idx);
      logic signed [ZW-1:0] v;
      begin
         unique case (idx)
            0:  v = 32'sd294912000;
            1:  v = 32'sd174096719;
            2:  v = 32'sd91987925;
            3:  v = 32'sd46694507;
            4:  v = 32'sd23437865;
            5:  v = 32'sd11730358;
            6:  v = 32'sd5866610;
            7:  v = 32'sd2933484;
            8:  v = 32'sd1466764;
            9:  v = 32'sd733385;
            10: v = 32'sd366693;
            11: v = 32'sd183346;
            12: v = 32'sd91673;
            13: v = 32'sd45837;
            14: v = 32'sd22918;
            15: v = 32'sd11459;
            16: v = 32'sd5730;
            17: v = 32'sd2865;
            18: v = 32'sd1432;
            19: v = 32'sd716;
            20: v = 32'sd358;
            21: v = 32'sd179;
            22: v = 32'sd90;
            23: v = 32'sd45;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/quaternion_to_euler_angles.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Attitude quaternion (Q1.14) to roll, pitch and yaw in centidegrees.
// ----------------------------------------------------------------------------
//  channel | handshake             | word
//  req     | req_valid/req_ready   | quat_w, quat_x, quat_y, quat_z
//  rsp     | rsp_valid/rsp_ready   | roll_cdeg, pitch_cdeg, yaw_cdeg, pitch_clamped
//
//  One word in per cycle unless a result is stalled, one result per word, through
//  3 product/sum stages, 31 square root stages, CORDIC_STEPS + 2 CORDIC stages
//  and the output register. The square root pipeline sets the depth.
//  Reset clears only the valid bits. A stalled result freezes the whole pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles #(
   parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [q2e_pkg::QW-1:0]          req_quat_w,
   input  wire logic signed [q2e_pkg::QW-1:0]          req_quat_x,
   input  wire logic signed [q2e_pkg::QW-1:0]          req_quat_y,
   input  wire logic signed [q2e_pkg::QW-1:0]          req_quat_z,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed      [q2e_pkg::ANG_W-1:0]       rsp_roll_cdeg,
   output logic signed      [q2e_pkg::PITCH_W-1:0]     rsp_pitch_cdeg,
   output logic signed      [q2e_pkg::ANG_W-1:0]       rsp_yaw_cdeg,
   output logic                                        rsp_pitch_clamped
);

   localparam int OPW  = q2e_pkg::OPW;
   localparam int PW   = q2e_pkg::PROD_W;
   localparam int F2   = 2 * q2e_pkg::QUAT_FRAC_BITS;
   localparam int SQS  = q2e_pkg::SQRT_STAGES;
   localparam int CLAT = CORDIC_STEPS + 2;
   localparam int LAT  = 3 + SQS + CLAT + 1;
   localparam logic signed [OPW-1:0] ONE = OPW'(1) <<< F2;

   typedef struct packed {
      logic signed [OPW-1:0]            sinr;
      logic signed [OPW-1:0]            cosr;
      logic signed [OPW-1:0]            siny;
      logic signed [OPW-1:0]            cosy;
      logic signed [q2e_pkg::SINE_W-1:0] s;
      logic                             clamp_pos;
      logic                             clamp_neg;
   } ops_type;

   typedef struct packed {
      logic clamp_pos;
      logic clamp_neg;
   } flags_type;

   logic en;
   logic [LAT-1:0] v_ff, v_in;

   assign en        = ~rsp_valid | rsp_ready;
   assign req_ready = en;

   always_comb begin
      v_in = {v_ff[LAT-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   assign rsp_valid = v_ff[LAT-1];

   // stage 1: component products
   logic signed [PW-1:0] wx_ff, yz_ff, wy_ff, zx_ff, wz_ff, xy_ff, xx_ff, yy_ff, zz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= req_quat_w * req_quat_x;
         yz_ff <= req_quat_y * req_quat_z;
         wy_ff <= req_quat_w * req_quat_y;
         zx_ff <= req_quat_z * req_quat_x;
         wz_ff <= req_quat_w * req_quat_z;
         xy_ff <= req_quat_x * req_quat_y;
         xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;
         zz_ff <= req_quat_z * req_quat_z;
      end
   end

   // stage 2: sums, pitch sine scaling and clamp test
   ops_type s2_in, s2_ff;
   logic signed [OPW-1:0] sinp;
   logic signed [q2e_pkg::SINE_W-1:0] s_scaled;
   logic signed [OPW-1:0] s_wide;

   assign sinp = (OPW'(wy_ff) - OPW'(zx_ff)) <<< 1;

   if (F2 >= 30) begin : g_sdown
      assign s_wide = sinp >>> (F2 - 30);
   end else begin : g_sup
      assign s_wide = sinp <<< (30 - F2);
   end
   assign s_scaled = s_wide[q2e_pkg::SINE_W-1:0];

   always_comb begin
      s2_in.sinr = (OPW'(wx_ff) + OPW'(yz_ff)) <<< 1;
      s2_in.cosr = ONE - ((OPW'(xx_ff) + OPW'(yy_ff)) <<< 1);
      s2_in.siny = (OPW'(wz_ff) + OPW'(xy_ff)) <<< 1;
      s2_in.cosy = ONE - ((OPW'(yy_ff) + OPW'(zz_ff)) <<< 1);
      s2_in.clamp_pos = (sinp >= ONE);
      s2_in.clamp_neg = (sinp <= -ONE);
      s2_in.s = s_scaled;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: 2^60 - s^2 for the cosine root
   ops_type s3_ff;
   logic signed [2*q2e_pkg::SINE_W-1:0] s_sq;
   logic [q2e_pkg::SQ_IN_W-1:0] rad_in, rad_ff;

   always_comb begin
      s_sq   = s2_ff.s * s2_ff.s;
      rad_in = q2e_pkg::SQ_IN_W'((62'(1) << 60) - 62'(s_sq));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff  <= s2_ff;
         rad_ff <= rad_in;
      end
   end

   // operands wait alongside the root pipeline
   logic [q2e_pkg::ROOT_W-1:0] root;
   ops_type dly_ff [SQS];

   q2e_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (rad_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= s3_ff;
         for (int k = 1; k < SQS; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   // three atan2 pipes
   logic signed [q2e_pkg::ANG_W-1:0] roll_a, pitch_a, yaw_a;
   logic signed [OPW-1:0] pitch_y, pitch_x;

   assign pitch_y = OPW'(dly_ff[SQS-1].s);
   assign pitch_x = $signed(OPW'(root));

   q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock (clock), .en (en),
      .op_y  (dly_ff[SQS-1].sinr), .op_x (dly_ff[SQS-1].cosr),
      .angle (roll_a)
   );

   q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock (clock), .en (en),
      .op_y  (pitch_y), .op_x (pitch_x),
      .angle (pitch_a)
   );

   q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
      .clock (clock), .en (en),
      .op_y  (dly_ff[SQS-1].siny), .op_x (dly_ff[SQS-1].cosy),
      .angle (yaw_a)
   );

   flags_type fl_ff [CLAT];

   always_ff @(posedge clock) begin
      if (en) begin
         fl_ff[0].clamp_pos <= dly_ff[SQS-1].clamp_pos;
         fl_ff[0].clamp_neg <= dly_ff[SQS-1].clamp_neg;
         for (int k = 1; k < CLAT; k++) begin
            fl_ff[k] <= fl_ff[k-1];
         end
      end
   end

   // output register
   logic signed [q2e_pkg::PITCH_W-1:0] pitch_in, pitch_ff;
   logic signed [q2e_pkg::ANG_W-1:0]   roll_ff, yaw_ff;
   logic                               clamped_ff;

   always_comb begin
      priority if (fl_ff[CLAT-1].clamp_pos) begin
         pitch_in = q2e_pkg::PITCH_MAX;
      end else if (fl_ff[CLAT-1].clamp_neg) begin
         pitch_in = -q2e_pkg::PITCH_MAX;
      end else if (pitch_a > q2e_pkg::ANG_W'(q2e_pkg::PITCH_MAX)) begin
         pitch_in = q2e_pkg::PITCH_MAX;
      end else if (pitch_a < -q2e_pkg::ANG_W'(q2e_pkg::PITCH_MAX)) begin
         pitch_in = -q2e_pkg::PITCH_MAX;
      end else begin
         pitch_in = pitch_a[q2e_pkg::PITCH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff    <= roll_a;
         yaw_ff     <= yaw_a;
         pitch_ff   <= pitch_in;
         clamped_ff <= fl_ff[CLAT-1].clamp_pos | fl_ff[CLAT-1].clamp_neg;
      end
   end

   assign rsp_roll_cdeg     = roll_ff;
   assign rsp_pitch_cdeg    = pitch_ff;
   assign rsp_yaw_cdeg      = yaw_ff;
   assign rsp_pitch_clamped = clamped_ff;

endmodule

`default_nettype wire

// ===== hdl/q2e_sqrt.sv =====
// ----------------------------------------------------------------------------
// q2e_sqrt
// Pipelined floored integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_sqrt (
   input  wire logic                             clock,
   input  wire logic                             en,
   input  wire logic [q2e_pkg::SQ_IN_W-1:0]      radicand,
   output logic      [q2e_pkg::ROOT_W-1:0]       root
);

   localparam int S  = q2e_pkg::SQRT_STAGES;
   localparam int RW = q2e_pkg::SQ_IN_W + 1;

   logic [RW-1:0] n_ff [S];
   logic [RW-1:0] r_ff [S];

   for (genvar k = 0; k < S; k++) begin : g_stage
      logic [RW-1:0] n_prev, r_prev, n_in, r_in, t;
      localparam logic [RW-1:0] BIT = RW'(1) << (2 * (S - 1 - k));

      if (k == 0) begin : g_first
         assign n_prev = RW'(radicand);
         assign r_prev = '0;
      end else begin : g_next
         assign n_prev = n_ff[k-1];
         assign r_prev = r_ff[k-1];
      end

      always_comb begin
         t = r_prev + BIT;
         if (n_prev >= t) begin
            n_in = n_prev - t;
            r_in = (r_prev >> 1) + BIT;
         end else begin
            n_in = n_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k] <= n_in;
            r_ff[k] <= r_in;
         end
      end
   end

   assign root = r_ff[S-1][q2e_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/q2e_cordic.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC atan2, one rotation per stage, result rounded
// to centidegrees and saturated to +-180 degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic #(
   parameter int STEPS = q2e_pkg::CORDIC_STEPS
) (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic signed [q2e_pkg::OPW-1:0]      op_y,
   input  wire logic signed [q2e_pkg::OPW-1:0]      op_x,
   output logic signed      [q2e_pkg::ANG_W-1:0]    angle
);

   localparam int W  = q2e_pkg::CW;
   localparam int ZW = q2e_pkg::ZW;

   logic signed [W-1:0]  x_ff [STEPS+1];
   logic signed [W-1:0]  y_ff [STEPS+1];
   logic signed [ZW-1:0] z_ff [STEPS+1];
   logic                 zero_ff [STEPS+1];
   logic signed [q2e_pkg::ANG_W-1:0] angle_ff;

   // quadrant fold into the right half plane
   logic signed [W-1:0]  x0_in, y0_in, xe, ye;
   logic signed [ZW-1:0] z0_in;

   always_comb begin
      xe = W'(op_x);
      ye = W'(op_y);
      x0_in = xe;
      y0_in = ye;
      z0_in = '0;
      if (xe < 0) begin
         if (ye >= 0) begin
            x0_in = ye;
            y0_in = -xe;
            z0_in = q2e_pkg::NINETY_Z;
         end else begin
            x0_in = -ye;
            y0_in = xe;
            z0_in = -q2e_pkg::NINETY_Z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= (op_x == '0) && (op_y == '0);
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_iter
      localparam logic signed [ZW-1:0] ATAN = q2e_pkg::atan_tab(k);
      logic signed [W-1:0]  dx, dy, x_in, y_in;
      logic signed [ZW-1:0] z_in;

      always_comb begin
         dx = y_ff[k] >>> k;
         dy = x_ff[k] >>> k;
         if (y_ff[k] >= 0) begin
            x_in = x_ff[k] + dx;
            y_in = y_ff[k] - dy;
            z_in = z_ff[k] + ATAN;
         end else begin
            x_in = x_ff[k] - dx;
            y_in = y_ff[k] + dy;
            z_in = z_ff[k] - ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k+1]    <= x_in;
            y_ff[k+1]    <= y_in;
            z_ff[k+1]    <= z_in;
            zero_ff[k+1] <= zero_ff[k];
         end
      end
   end

   // round half up, then saturate
   logic signed [ZW-1:0] zr, zs;
   logic signed [q2e_pkg::ANG_W-1:0] angle_in;

   always_comb begin
      zr = z_ff[STEPS] + (ZW'(1) <<< (q2e_pkg::ANG_FRAC - 1));
      zs = zr >>> q2e_pkg::ANG_FRAC;
      priority if (zero_ff[STEPS]) begin
         angle_in = '0;
      end else if (zs > ZW'(q2e_pkg::ANG_MAX)) begin
         angle_in = q2e_pkg::ANG_MAX;
      end else if (zs < -ZW'(q2e_pkg::ANG_MAX)) begin
         angle_in = -q2e_pkg::ANG_MAX;
      end else begin
         angle_in = zs[q2e_pkg::ANG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

`default_nettype wire

// ===== sim/tb_quaternion_to_euler_angles.sv =====
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles
// Drives quaternion words through the Euler angle pipeline with random gaps on
// both channels and checks every result word against a local angle predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quaternion_to_euler_angles;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [q2e_pkg::ANG_W-1:0]   roll;
      logic signed [q2e_pkg::PITCH_W-1:0] pitch;
      logic signed [q2e_pkg::ANG_W-1:0]   yaw;
      logic                               clamped;
   } angles_type;

   localparam int QFRAC      = 14;
   localparam int NSTEPS     = 16;
   localparam int AFRAC      = 16;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [q2e_pkg::QW-1:0] req_quat_w = '0, req_quat_x = '0;
   logic signed [q2e_pkg::QW-1:0] req_quat_y = '0, req_quat_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [q2e_pkg::ANG_W-1:0]   rsp_roll_cdeg, rsp_yaw_cdeg;
   logic signed [q2e_pkg::PITCH_W-1:0] rsp_pitch_cdeg;
   logic rsp_pitch_clamped;

   angles_type expected_angles[$];
   int      n_errors = 0;
   int      n_words = 0;
   int      n_results = 0;
   int      n_clamped = 0;
   longint  cycles = 0;
   bit      sink_steady = 1'b0;

   quaternion_to_euler_angles dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_quat_w(req_quat_w), .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_roll_cdeg(rsp_roll_cdeg), .rsp_pitch_cdeg(rsp_pitch_cdeg),
      .rsp_yaw_cdeg(rsp_yaw_cdeg), .rsp_pitch_clamped(rsp_pitch_clamped)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(root);
   endfunction

   function automatic longint arctan_tab(int i);
      longint t[24] = '{294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
                        5866610, 2933484, 1466764, 733385, 366693, 183346,
                        91673, 45837, 22918, 11459, 5730, 2865,
                        1432, 716, 358, 179, 90, 45};
      return t[i];
   endfunction

   // vectoring atan2, centidegrees, saturated to +-18000
   function automatic longint atan2_cdeg(longint yv, longint xv);
      longint ang, tmp, dx, dy, r;
      ang = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         tmp = xv;
         if (yv >= 0) begin
            xv = yv; yv = -tmp; ang = 64'sd9000 <<< AFRAC;
         end else begin
            xv = -yv; yv = tmp; ang = -(64'sd9000 <<< AFRAC);
         end
      end
      for (int i = 0; i < NSTEPS; i++) begin
         dx = floor_shift(yv, i);
         dy = floor_shift(xv, i);
         if (yv >= 0) begin
            xv += dx; yv -= dy; ang += arctan_tab(i);
         end else begin
            xv -= dx; yv += dy; ang -= arctan_tab(i);
         end
      end
      r = floor_shift(ang + (64'sd1 <<< (AFRAC - 1)), AFRAC);
      if (r > 18000) r = 18000;
      if (r < -18000) r = -18000;
      return r;
   endfunction

   function automatic angles_type quat_to_angles(longint w, longint x, longint y, longint z);
      angles_type a;
      longint unity, sinr, cosr, sinp, siny, cosy, s, c, p;
      unity = 64'sd1 <<< (2 * QFRAC);
      sinr = 2 * (w * x + y * z);
      cosr = unity - 2 * (x * x + y * y);
      sinp = 2 * (w * y - z * x);
      siny = 2 * (w * z + x * y);
      cosy = unity - 2 * (y * y + z * z);
      a.clamped = 1'b0;
      if (sinp >= unity) begin
         p = 9000; a.clamped = 1'b1;
      end else if (sinp <= -unity) begin
         p = -9000; a.clamped = 1'b1;
      end else begin
         s = sinp * (64'sd1 <<< (30 - 2 * QFRAC));
         c = int_sqrt((64'd1 << 60) - longint'(s * s));
         p = atan2_cdeg(s, c);
         if (p > 9000) p = 9000;
         if (p < -9000) p = -9000;
      end
      a.roll  = q2e_pkg::ANG_W'(atan2_cdeg(sinr, cosr));
      a.pitch = q2e_pkg::PITCH_W'(p);
      a.yaw   = q2e_pkg::ANG_W'(atan2_cdeg(siny, cosy));
      return a;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_quaternion_to_euler_angles: done, errors");
         $finish;
      end
   end

   // result sink: random stalls, occasionally a long always-ready stretch
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = sink_steady ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      angles_type exp_a;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (expected_angles.size() == 0) begin
            $error("result word with nothing expected");
            n_errors++;
         end else begin
            exp_a = expected_angles.pop_front();
            if (rsp_roll_cdeg !== exp_a.roll) begin
               $error("roll_cdeg exp %0d got %0d", exp_a.roll, rsp_roll_cdeg); n_errors++;
            end
            if (rsp_pitch_cdeg !== exp_a.pitch) begin
               $error("pitch_cdeg exp %0d got %0d", exp_a.pitch, rsp_pitch_cdeg); n_errors++;
            end
            if (rsp_yaw_cdeg !== exp_a.yaw) begin
               $error("yaw_cdeg exp %0d got %0d", exp_a.yaw, rsp_yaw_cdeg); n_errors++;
            end
            if (rsp_pitch_clamped !== exp_a.clamped) begin
               $error("pitch_clamped exp %0b got %0b", exp_a.clamped, rsp_pitch_clamped);
               n_errors++;
            end
         end
      end
   end

   task automatic send_quat(int w, int x, int y, int z, bit no_gap = 0);
      int gap;
      angles_type a;
      gap = no_gap ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_quat_w <= q2e_pkg::QW'(w);
      req_quat_x <= q2e_pkg::QW'(x);
      req_quat_y <= q2e_pkg::QW'(y);
      req_quat_z <= q2e_pkg::QW'(z);
      a = quat_to_angles(w, x, y, z);
      do @(posedge clock); while (!req_ready);
      expected_angles.push_back(a);
      n_words++;
      if (a.clamped) n_clamped++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_angles.size() != 0) @(posedge clock);
   endtask

   function automatic int rand_comp();
      return $urandom_range(0, 32768) - 16384;
   endfunction

   task automatic test_extremes();
      send_quat(16384, 0, 0, 0);
      send_quat(0, 0, 0, 0);
      send_quat(-16384, -16384, -16384, -16384);
      send_quat(16384, 16384, 16384, 16384);
      send_quat(16384, -16384, 16384, -16384);
      send_quat(-1, -1, -1, -1);
      send_quat(1, -1, 1, -1);
      send_quat(0, 16384, 0, 0);         // roll x negative, y zero
      send_quat(0, 0, 0, 16384);         // yaw x negative, y zero
      send_quat(0, 0, 16384, 0);
      send_quat(11585, 0, 11585, 0);     // near gimbal lock, pitch close to +90
      send_quat(11585, 0, -11585, 0);    // pitch close to -90
      send_quat(11586, 0, 11586, 0);     // sine past one
      send_quat(11584, 0, 11584, 0);     // just under clamp
      send_quat(11585, 11585, 0, 0);
      send_quat(11585, 0, 0, -11585);
      send_quat(-16384, 0, 16384, 0);
      send_quat(16384, 0, -16384, 16384);
   endtask

   task automatic test_unit_random(int count);
      real w, x, y, z, nrm;
      for (int i = 0; i < count; i++) begin
         do begin
            w = rand_comp(); x = rand_comp(); y = rand_comp(); z = rand_comp();
            nrm = $sqrt(w * w + x * x + y * y + z * z);
         end while (nrm < 1.0);
         send_quat(int'(w * 16384.0 / nrm), int'(x * 16384.0 / nrm),
                   int'(y * 16384.0 / nrm), int'(z * 16384.0 / nrm));
      end
   endtask

   // near gimbal lock: w and y close to equal magnitude
   task automatic test_near_lock(int count);
      int m, d;
      for (int i = 0; i < count; i++) begin
         m = $urandom_range(11500, 11700);
         d = $urandom_range(0, 8) - 4;
         send_quat(($urandom_range(0, 1) ? m : -m), $urandom_range(0, 20) - 10,
                   ($urandom_range(0, 1) ? m + d : -(m + d)), $urandom_range(0, 20) - 10);
      end
   endtask

   task automatic test_raw_random(int count);
      for (int i = 0; i < count; i++)
         send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
   endtask

   task automatic test_back_to_back(int count);
      sink_steady = 1'b1;
      for (int i = 0; i < count; i++)
         send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 1'b1);
      drain_results();
      sink_steady = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      drain_results();                   // sender holds off until all results are in
      test_unit_random(450);
      test_near_lock(120);
      test_raw_random(300);
      test_back_to_back(80);
      drain_results();
      repeat (80) @(posedge clock);
      $display("covered %0d quaternion words, %0d results, %0d with pitch clamped",
               n_words, n_results, n_clamped);
      if (n_errors == 0 && expected_angles.size() == 0) begin
         $display("tb_quaternion_to_euler_angles: done, clean");
      end else begin
         $display("tb_quaternion_to_euler_angles: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
